FILE: rtl/tpgt_pkg.sv
// Shared types, event codes and helpers for the trackpad pan gesture tracker.
`default_nettype none
package tpgt_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned TIME_W  = 64;
    localparam int unsigned DELTA_W = 24;
    localparam int unsigned POS_W   = 24;
    localparam int unsigned PAN_W   = 32;
    localparam int unsigned DEV_W   = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_NATURAL_SCROLL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_NUMBER  = 1'd1;

    // Input operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result phase codes
    localparam logic [PHASE_W-1:0] PH_ADD    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_UPDATE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_END    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_REMOVE = 3'd4;

    // Event mask bit positions, in emission order
    localparam int unsigned EV_COUNT  = 5;
    localparam int unsigned EV_IDX_W  = 3;
    localparam int unsigned EV_ADD    = 0;
    localparam int unsigned EV_START  = 1;
    localparam int unsigned EV_UPDATE = 2;
    localparam int unsigned EV_END    = 3;
    localparam int unsigned EV_REMOVE = 4;

    typedef logic [EV_COUNT-1:0] ev_mask_t;

    typedef struct packed {
        logic              natural_scroll;
        logic [DEV_W-1:0]  device_number;
    } tpgt_cfg_t;

    // One classified input: the events it causes and the data they report
    typedef struct packed {
        ev_mask_t                  events;
        logic [TIME_W-1:0]         time_stamp;
        logic [POS_W-1:0]          pos_horizontal;
        logic [POS_W-1:0]          pos_vertical;
        logic signed [PAN_W-1:0]   pan_horizontal;
        logic signed [PAN_W-1:0]   pan_vertical;
    } tpgt_entry_t;

    function automatic logic [PHASE_W-1:0] ev_phase(input logic [EV_IDX_W-1:0] idx);
        logic [PHASE_W-1:0] ph;
        case (idx)
            EV_IDX_W'(EV_ADD):    ph = PH_ADD;
            EV_IDX_W'(EV_START):  ph = PH_START;
            EV_IDX_W'(EV_UPDATE): ph = PH_UPDATE;
            EV_IDX_W'(EV_END):    ph = PH_END;
            default:              ph = PH_REMOVE;
        endcase
        return ph;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tpgt_front.sv
// Front end: accepts items, tracks gesture state and classifies each item into events.
`default_nettype none
module tpgt_front (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire tpgt_pkg::tpgt_cfg_t             cfg,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire                                  operation,
    input  wire [tpgt_pkg::TIME_W-1:0]           time_stamp,
    input  wire                                  has_horizontal,
    input  wire                                  has_vertical,
    input  wire signed [tpgt_pkg::DELTA_W-1:0]   delta_horizontal,
    input  wire signed [tpgt_pkg::DELTA_W-1:0]   delta_vertical,
    input  wire [tpgt_pkg::POS_W-1:0]            pos_horizontal,
    input  wire [tpgt_pkg::POS_W-1:0]            pos_vertical,
    input  wire                                  q_full,
    output logic                                 q_push,
    output tpgt_pkg::tpgt_entry_t                q_entry
);

    localparam int unsigned DW = tpgt_pkg::DELTA_W;
    localparam int unsigned PW = tpgt_pkg::PAN_W;
    localparam int unsigned SW = PW + 2;

    logic                       active_reg, active_next;
    logic                       added_reg, added_next;
    logic                       hmov_reg, hmov_next;
    logic                       vmov_reg, vmov_next;
    logic [tpgt_pkg::POS_W-1:0] lat_h_reg, lat_h_next;
    logic [tpgt_pkg::POS_W-1:0] lat_v_reg, lat_v_next;
    logic signed [PW-1:0]       tot_h_reg, tot_h_next;
    logic signed [PW-1:0]       tot_v_reg, tot_v_next;

    logic signed [DW-1:0]       dx, dy;
    logic signed [DW:0]         sx, sy;
    logic signed [SW-1:0]       sum_h, sum_v;
    logic signed [PW-1:0]       base_h, base_v, sat_h, sat_v;
    logic                       moved, starting, accept;
    tpgt_pkg::ev_mask_t         events;

    function automatic logic signed [PW-1:0] sat_pan(input logic signed [SW-1:0] v);
        logic signed [PW-1:0] r;
        if (v[SW-1:PW-1] == '0 || v[SW-1:PW-1] == '1)
            r = v[PW-1:0];
        else if (v[SW-1])
            r = {1'b1, {(PW-1){1'b0}}};
        else
            r = {1'b0, {(PW-1){1'b1}}};
        return r;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        dx       = has_horizontal ? delta_horizontal : '0;
        dy       = has_vertical   ? delta_vertical   : '0;
        moved    = (dx != '0) || (dy != '0);
        starting = !active_reg && moved;

        // Negate unless natural scrolling; one extra bit covers the most negative delta
        sx = cfg.natural_scroll ? {dx[DW-1], dx} : -{dx[DW-1], dx};
        sy = cfg.natural_scroll ? {dy[DW-1], dy} : -{dy[DW-1], dy};

        base_h = starting ? '0 : tot_h_reg;
        base_v = starting ? '0 : tot_v_reg;
        sum_h  = {{2{base_h[PW-1]}}, base_h} + {{(SW-DW-1){sx[DW]}}, sx};
        sum_v  = {{2{base_v[PW-1]}}, base_v} + {{(SW-DW-1){sy[DW]}}, sy};
        sat_h  = sat_pan(sum_h);
        sat_v  = sat_pan(sum_v);

        active_next = active_reg;
        added_next  = added_reg;
        hmov_next   = hmov_reg;
        vmov_next   = vmov_reg;
        lat_h_next  = lat_h_reg;
        lat_v_next  = lat_v_reg;
        tot_h_next  = tot_h_reg;
        tot_v_next  = tot_v_reg;
        events      = '0;

        if (operation == tpgt_pkg::OP_REMOVE)
        begin
            events[tpgt_pkg::EV_END]    = active_reg;
            events[tpgt_pkg::EV_REMOVE] = added_reg;
            active_next = 1'b0;
            added_next  = 1'b0;
            hmov_next   = 1'b0;
            vmov_next   = 1'b0;
            lat_h_next  = '0;
            lat_v_next  = '0;
            tot_h_next  = '0;
            tot_v_next  = '0;
        end
        else if (active_reg || moved)
        begin
            if (starting)
            begin
                lat_h_next = pos_horizontal;
                lat_v_next = pos_vertical;
                hmov_next  = 1'b0;
                vmov_next  = 1'b0;
                events[tpgt_pkg::EV_ADD]   = !added_reg;
                events[tpgt_pkg::EV_START] = 1'b1;
                added_next = 1'b1;
            end
            if (has_horizontal)
                hmov_next = (dx != '0);
            if (has_vertical)
                vmov_next = (dy != '0);
            tot_h_next = moved ? sat_h : base_h;
            tot_v_next = moved ? sat_v : base_v;
            events[tpgt_pkg::EV_UPDATE] = moved;
            events[tpgt_pkg::EV_END]    = !hmov_next && !vmov_next;
            active_next = hmov_next || vmov_next;
        end

        // Results report the totals held before a remove clears them
        q_entry.events         = events;
        q_entry.time_stamp     = time_stamp;
        q_entry.pos_horizontal = (operation == tpgt_pkg::OP_REMOVE) ? lat_h_reg : lat_h_next;
        q_entry.pos_vertical   = (operation == tpgt_pkg::OP_REMOVE) ? lat_v_reg : lat_v_next;
        q_entry.pan_horizontal = (operation == tpgt_pkg::OP_REMOVE) ? tot_h_reg : tot_h_next;
        q_entry.pan_vertical   = (operation == tpgt_pkg::OP_REMOVE) ? tot_v_reg : tot_v_next;
    end

    assign q_push = accept && (events != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            added_reg  <= 1'b0;
            hmov_reg   <= 1'b0;
            vmov_reg   <= 1'b0;
            lat_h_reg  <= '0;
            lat_v_reg  <= '0;
            tot_h_reg  <= '0;
            tot_v_reg  <= '0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            added_reg  <= added_next;
            hmov_reg   <= hmov_next;
            vmov_reg   <= vmov_next;
            lat_h_reg  <= lat_h_next;
            lat_v_reg  <= lat_v_next;
            tot_h_reg  <= tot_h_next;
            tot_v_reg  <= tot_v_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tpgt_queue.sv
// Short FIFO of classified items between the front and back ends.
`default_nettype none
module tpgt_queue #(
    parameter int unsigned DEPTH = tpgt_pkg::QUEUE_DEPTH
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  wire tpgt_pkg::tpgt_entry_t push_entry,
    input  wire                    pop,
    output logic                   full,
    output logic                   head_valid,
    output tpgt_pkg::tpgt_entry_t  head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tpgt_pkg::tpgt_entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tpgt_back.sv
// Back end: loads each item's events into the output register, one per cycle unless stalled.
`default_nettype none
module tpgt_back (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire tpgt_pkg::tpgt_cfg_t             cfg,
    input  wire                                  head_valid,
    input  wire tpgt_pkg::tpgt_entry_t           head,
    output logic                                 pop,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [tpgt_pkg::PHASE_W-1:0]         phase,
    output logic [tpgt_pkg::TIME_W-1:0]          out_time,
    output logic [tpgt_pkg::POS_W-1:0]           out_pos_horizontal,
    output logic [tpgt_pkg::POS_W-1:0]           out_pos_vertical,
    output logic signed [tpgt_pkg::PAN_W-1:0]    pan_horizontal,
    output logic signed [tpgt_pkg::PAN_W-1:0]    pan_vertical,
    output logic [tpgt_pkg::DEV_W-1:0]           device,
    output logic                                 last
);

    localparam int unsigned EC = tpgt_pkg::EV_COUNT;
    localparam int unsigned IW = tpgt_pkg::EV_IDX_W;

    tpgt_pkg::ev_mask_t        done_reg;
    tpgt_pkg::ev_mask_t        pending, sel;
    logic [IW-1:0]             sel_idx;
    logic [tpgt_pkg::PHASE_W-1:0] sel_phase;
    logic                      sel_last, load, zero_pan;

    logic                      out_valid_reg;
    logic [tpgt_pkg::PHASE_W-1:0] phase_reg;
    logic [tpgt_pkg::TIME_W-1:0]  time_reg;
    logic [tpgt_pkg::POS_W-1:0]   pos_h_reg, pos_v_reg;
    logic signed [tpgt_pkg::PAN_W-1:0] pan_h_reg, pan_v_reg;
    logic [tpgt_pkg::DEV_W-1:0]   dev_reg;
    logic                      last_reg;

    always_comb
    begin
        pending = head.events & ~done_reg;
        sel     = '0;
        sel_idx = '0;
        // Lowest pending bit goes first
        for (int i = EC - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                sel     = '0;
                sel[i]  = 1'b1;
                sel_idx = IW'(i);
            end
        end
        sel_phase = tpgt_pkg::ev_phase(sel_idx);
        sel_last  = ((pending & ~sel) == '0);
        zero_pan  = (sel_phase == tpgt_pkg::PH_ADD) || (sel_phase == tpgt_pkg::PH_START);
    end

    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && sel_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                done_reg      <= sel_last ? '0 : (done_reg | sel);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            phase_reg <= sel_phase;
            time_reg  <= head.time_stamp;
            pos_h_reg <= head.pos_horizontal;
            pos_v_reg <= head.pos_vertical;
            pan_h_reg <= zero_pan ? '0 : head.pan_horizontal;
            pan_v_reg <= zero_pan ? '0 : head.pan_vertical;
            dev_reg   <= cfg.device_number;
            last_reg  <= sel_last;
        end
    end

    assign out_valid          = out_valid_reg;
    assign phase              = phase_reg;
    assign out_time           = time_reg;
    assign out_pos_horizontal = pos_h_reg;
    assign out_pos_vertical   = pos_v_reg;
    assign pan_horizontal     = pan_h_reg;
    assign pan_vertical       = pan_v_reg;
    assign device             = dev_reg;
    assign last               = last_reg;

endmodule
`default_nettype wire

FILE: rtl/trackpad_pan_gesture_tracker.sv
// Top level of the trackpad pan gesture tracker: config registers, front end, queue, back end.
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------
//  in      | in_valid / in_ready   | operation, time_stamp, has_*, delta_*, pos_*
//  out     | out_valid / out_ready | phase, out_time, out_pos_*, pan_*, device, last
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// An item is classified in the cycle it is accepted; its one to three events leave the
// output register one per cycle while out_ready holds, and an item with no events is
// not queued. The back end's single output register limits the flow of events.
// The queue lets the front keep accepting while the output stalls; in_ready drops only
// when the queue is full. Reset is asynchronous and needs no clearing pass.
`default_nettype none
module trackpad_pan_gesture_tracker #(
    parameter int unsigned QUEUE_DEPTH = tpgt_pkg::QUEUE_DEPTH
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     cfg_valid,
    output logic                                    cfg_ready,
    input  wire [tpgt_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  wire [tpgt_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  wire                                     in_valid,
    output logic                                    in_ready,
    input  wire                                     operation,
    input  wire [tpgt_pkg::TIME_W-1:0]              time_stamp,
    input  wire                                     has_horizontal,
    input  wire                                     has_vertical,
    input  wire signed [tpgt_pkg::DELTA_W-1:0]      delta_horizontal,
    input  wire signed [tpgt_pkg::DELTA_W-1:0]      delta_vertical,
    input  wire [tpgt_pkg::POS_W-1:0]               pos_horizontal,
    input  wire [tpgt_pkg::POS_W-1:0]               pos_vertical,
    output logic                                    out_valid,
    input  wire                                     out_ready,
    output logic [tpgt_pkg::PHASE_W-1:0]            phase,
    output logic [tpgt_pkg::TIME_W-1:0]             out_time,
    output logic [tpgt_pkg::POS_W-1:0]              out_pos_horizontal,
    output logic [tpgt_pkg::POS_W-1:0]              out_pos_vertical,
    output logic signed [tpgt_pkg::PAN_W-1:0]       pan_horizontal,
    output logic signed [tpgt_pkg::PAN_W-1:0]       pan_vertical,
    output logic [tpgt_pkg::DEV_W-1:0]              device,
    output logic                                    last
);

    tpgt_pkg::tpgt_cfg_t    cfg_reg;
    tpgt_pkg::tpgt_entry_t  push_entry, head;
    logic                   q_push, q_full, q_pop, head_valid;

    // Configuration must be written only while idle (the block does not enforce this), so both ends read it directly
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.natural_scroll <= 1'b1;
            cfg_reg.device_number  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tpgt_pkg::CFG_NATURAL_SCROLL: cfg_reg.natural_scroll <= cfg_data[0];
                tpgt_pkg::CFG_DEVICE_NUMBER:  cfg_reg.device_number  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Classify each accepted item and advance the gesture state
    tpgt_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .time_stamp       (time_stamp),
        .has_horizontal   (has_horizontal),
        .has_vertical     (has_vertical),
        .delta_horizontal (delta_horizontal),
        .delta_vertical   (delta_vertical),
        .pos_horizontal   (pos_horizontal),
        .pos_vertical     (pos_vertical),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_entry          (push_entry)
    );

    // Hold classified items until the back end drains them
    tpgt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Emit one event per cycle from the queue head while out_ready holds
    tpgt_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .head_valid         (head_valid),
        .head               (head),
        .pop                (q_pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .phase              (phase),
        .out_time           (out_time),
        .out_pos_horizontal (out_pos_horizontal),
        .out_pos_vertical   (out_pos_vertical),
        .pan_horizontal     (pan_horizontal),
        .pan_vertical       (pan_vertical),
        .device             (device),
        .last               (last)
    );

`ifndef ASSERT_OFF
    // Add and start always report freshly cleared totals
    a_zero_pan_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == tpgt_pkg::PH_ADD || phase == tpgt_pkg::PH_START)
        |-> (pan_horizontal == '0) && (pan_vertical == '0))
        else $error("add/start event with nonzero pan total");

    // Remove is always the final event of its item
    a_remove_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == tpgt_pkg::PH_REMOVE) |-> last)
        else $error("remove event not marked last");

    // Add is always followed by start for the same item
    a_add_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == tpgt_pkg::PH_ADD) |-> !last)
        else $error("add event marked last");
`endif

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the trackpad pan gesture tracker: stimulus, prediction, checks.
`timescale 1ns / 100ps
module testbench;

    localparam int unsigned TIME_W      = tpgt_pkg::TIME_W;
    localparam int unsigned DELTA_W     = tpgt_pkg::DELTA_W;
    localparam int unsigned POS_W       = tpgt_pkg::POS_W;
    localparam int unsigned PAN_W       = tpgt_pkg::PAN_W;
    localparam int unsigned DEV_W       = tpgt_pkg::DEV_W;
    localparam int unsigned PHASE_W     = tpgt_pkg::PHASE_W;
    localparam int unsigned CFG_INDEX_W = tpgt_pkg::CFG_INDEX_W;
    localparam int unsigned CFG_DATA_W  = tpgt_pkg::CFG_DATA_W;

    // Hold-off after the last result before touching the registers or ending the run,
    // so that a stray extra result has time to show up.
    localparam int SETTLE_CYCLES  = 12;
    // Longest quiet stretch of a correct run is a long gap or stall or the settle pause;
    // allow many times that.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [DELTA_W-1:0] DELTA_MAX = 24'sh7FFFFF;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = 24'sh800000;
    localparam logic [POS_W-1:0]          POS_MAX   = 24'hFFFFFF;
    localparam logic [TIME_W-1:0]         TIME_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;

    // One input transaction as the sender sees it
    typedef struct {
        logic                      op;
        logic [TIME_W-1:0]         stamp;
        logic                      has_h;
        logic                      has_v;
        logic signed [DELTA_W-1:0] d_h;
        logic signed [DELTA_W-1:0] d_v;
        logic [POS_W-1:0]          p_h;
        logic [POS_W-1:0]          p_v;
    } finger_item_t;

    // One gesture event as the output channel should carry it
    typedef struct {
        logic [PHASE_W-1:0]      ph;
        logic [TIME_W-1:0]       stamp;
        logic [POS_W-1:0]        pos_h;
        logic [POS_W-1:0]        pos_v;
        logic signed [PAN_W-1:0] pan_h;
        logic signed [PAN_W-1:0] pan_v;
        logic [DEV_W-1:0]        dev;
        logic                    is_last;
    } gesture_event_t;

    logic clk;
    logic rst_n;

    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    logic                     in_valid;
    logic                     in_ready;
    logic                     operation;
    logic [TIME_W-1:0]        time_stamp;
    logic                     has_horizontal;
    logic                     has_vertical;
    logic signed [DELTA_W-1:0] delta_horizontal;
    logic signed [DELTA_W-1:0] delta_vertical;
    logic [POS_W-1:0]         pos_horizontal;
    logic [POS_W-1:0]         pos_vertical;

    logic                     out_valid;
    logic                     out_ready;
    logic [PHASE_W-1:0]       phase;
    logic [TIME_W-1:0]        out_time;
    logic [POS_W-1:0]         out_pos_horizontal;
    logic [POS_W-1:0]         out_pos_vertical;
    logic signed [PAN_W-1:0]  pan_horizontal;
    logic signed [PAN_W-1:0]  pan_vertical;
    logic [DEV_W-1:0]         device;
    logic                     last;

    // Shadow copy of the tracker: registers and gesture state
    logic                    cfg_natural;
    logic [DEV_W-1:0]        cfg_device;
    logic                    trk_active;
    logic                    trk_added;
    logic                    trk_h_moving;
    logic                    trk_v_moving;
    logic [POS_W-1:0]        trk_lat_h;
    logic [POS_W-1:0]        trk_lat_v;
    logic signed [PAN_W-1:0] trk_pan_h;
    logic signed [PAN_W-1:0] trk_pan_v;

    // Events predicted but not yet seen on the output, oldest first
    gesture_event_t pending_events[$];

    int  error_count     = 0;
    int  effective_items = 0;
    int  quiet_cycles    = 0;
    bit  idle_on         = 1'b1;

    trackpad_pan_gesture_tracker dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .operation          (operation),
        .time_stamp         (time_stamp),
        .has_horizontal     (has_horizontal),
        .has_vertical       (has_vertical),
        .delta_horizontal   (delta_horizontal),
        .delta_vertical     (delta_vertical),
        .pos_horizontal     (pos_horizontal),
        .pos_vertical       (pos_vertical),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .phase              (phase),
        .out_time           (out_time),
        .out_pos_horizontal (out_pos_horizontal),
        .out_pos_vertical   (out_pos_vertical),
        .pan_horizontal     (pan_horizontal),
        .pan_vertical       (pan_vertical),
        .device             (device),
        .last               (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Return the tracker to its post-reset gesture state; registers stay.
    function automatic void clear_gesture_state();
        trk_active   = 1'b0;
        trk_added    = 1'b0;
        trk_h_moving = 1'b0;
        trk_v_moving = 1'b0;
        trk_lat_h    = '0;
        trk_lat_v    = '0;
        trk_pan_h    = '0;
        trk_pan_v    = '0;
    endfunction

    // Clamp a wide sum to the signed 32-bit pan range.
    function automatic logic signed [PAN_W-1:0] saturate_pan(input longint sum);
        if (sum > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (sum < -longint'(64'sh8000_0000))
            return 32'sh8000_0000;
        return PAN_W'(sum);
    endfunction

    // Snapshot of the current gesture state as one event.
    function automatic gesture_event_t make_event(input logic [PHASE_W-1:0] ph,
                                                  input logic [TIME_W-1:0] stamp);
        gesture_event_t ev;
        ev.ph      = ph;
        ev.stamp   = stamp;
        ev.pos_h   = trk_lat_h;
        ev.pos_v   = trk_lat_v;
        ev.pan_h   = trk_pan_h;
        ev.pan_v   = trk_pan_v;
        ev.dev     = cfg_device;
        ev.is_last = 1'b0;
        return ev;
    endfunction

    // Advance the shadow tracker by one accepted transaction and queue the
    // events it causes. Return 0 when the block simply drops the transaction.
    function automatic bit predict_gesture_events(input finger_item_t it);
        gesture_event_t          batch[$];
        logic signed [DELTA_W-1:0] dh;
        logic signed [DELTA_W-1:0] dv;
        bit                      moved;
        bit                      touched;
        longint                  step_h;
        longint                  step_v;
        touched = 1'b1;
        if (it.op == tpgt_pkg::OP_REMOVE)
        begin
            // Close the open gesture, report the removal, snapshot before clearing
            touched = trk_active || trk_added;
            if (trk_active)
                batch.push_back(make_event(tpgt_pkg::PH_END, it.stamp));
            if (trk_added)
                batch.push_back(make_event(tpgt_pkg::PH_REMOVE, it.stamp));
            clear_gesture_state();
        end
        else
        begin
            // An axis that is not reported counts as zero motion
            dh    = it.has_h ? it.d_h : '0;
            dv    = it.has_v ? it.d_v : '0;
            moved = (dh != 0) || (dv != 0);
            if (!trk_active && !moved)
                touched = 1'b0;
            else
            begin
                if (!trk_active)
                begin
                    trk_lat_h    = it.p_h;
                    trk_lat_v    = it.p_v;
                    trk_pan_h    = '0;
                    trk_pan_v    = '0;
                    trk_h_moving = 1'b0;
                    trk_v_moving = 1'b0;
                    if (!trk_added)
                    begin
                        batch.push_back(make_event(tpgt_pkg::PH_ADD, it.stamp));
                        trk_added = 1'b1;
                    end
                    batch.push_back(make_event(tpgt_pkg::PH_START, it.stamp));
                    trk_active = 1'b1;
                end
                if (it.has_h)
                    trk_h_moving = (dh != 0);
                if (it.has_v)
                    trk_v_moving = (dv != 0);
                if (moved)
                begin
                    step_h    = cfg_natural ? longint'(dh) : -longint'(dh);
                    step_v    = cfg_natural ? longint'(dv) : -longint'(dv);
                    trk_pan_h = saturate_pan(longint'(trk_pan_h) + step_h);
                    trk_pan_v = saturate_pan(longint'(trk_pan_v) + step_v);
                    batch.push_back(make_event(tpgt_pkg::PH_UPDATE, it.stamp));
                end
                if (!trk_h_moving && !trk_v_moving)
                begin
                    batch.push_back(make_event(tpgt_pkg::PH_END, it.stamp));
                    trk_active = 1'b0;
                end
            end
        end
        // Flag the final event of this transaction
        if (batch.size() > 0)
            batch[batch.size()-1].is_last = 1'b1;
        foreach (batch[i])
            pending_events.push_back(batch[i]);
        return touched;
    endfunction

    // ------------------------------------------------------------------
    // Random sources
    // ------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short gap, now and then a long gap.
    function automatic int pick_gap();
        int roll;
        if (!idle_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    // Zero, full-range, extreme or small deltas in a rough mix.
    function automatic logic signed [DELTA_W-1:0] rand_delta();
        case ($urandom_range(0, 5))
            0:
                return '0;
            1:
                return DELTA_W'($urandom);
            2:
                case ($urandom_range(0, 3))
                    0:       return DELTA_MAX;
                    1:       return DELTA_MIN;
                    2:       return 24'sd1;
                    default: return -24'sd1;
                endcase
            default:
                return DELTA_W'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    function automatic logic signed [DELTA_W-1:0] nonzero_delta();
        logic signed [DELTA_W-1:0] d;
        do
            d = rand_delta();
        while (d == 0);
        return d;
    endfunction

    // Every field random, the operation too.
    function automatic finger_item_t noise_item();
        finger_item_t it;
        it.op    = 1'($urandom_range(0, 1));
        it.stamp = rand_time();
        it.has_h = 1'($urandom_range(0, 1));
        it.has_v = 1'($urandom_range(0, 1));
        it.d_h   = rand_delta();
        it.d_v   = rand_delta();
        it.p_h   = POS_W'($urandom);
        it.p_v   = POS_W'($urandom);
        return it;
    endfunction

    function automatic finger_item_t sample_item(input logic hh, input logic hv,
                                                 input logic signed [DELTA_W-1:0] dh,
                                                 input logic signed [DELTA_W-1:0] dv,
                                                 input logic [POS_W-1:0] ph,
                                                 input logic [POS_W-1:0] pv,
                                                 input logic [TIME_W-1:0] stamp);
        finger_item_t it;
        it.op    = tpgt_pkg::OP_SAMPLE;
        it.stamp = stamp;
        it.has_h = hh;
        it.has_v = hv;
        it.d_h   = dh;
        it.d_v   = dv;
        it.p_h   = ph;
        it.p_v   = pv;
        return it;
    endfunction

    // Sample fields of a remove are don't-care: fill them with noise.
    function automatic finger_item_t remove_item(input logic [TIME_W-1:0] stamp);
        finger_item_t it;
        it       = noise_item();
        it.op    = tpgt_pkg::OP_REMOVE;
        it.stamp = stamp;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Send one transaction; valid stays high afterward so a zero gap
    // gives back-to-back transactions.
    task automatic drive_item(input finger_item_t it);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid         <= 1'b1;
        operation        <= it.op;
        time_stamp       <= it.stamp;
        has_horizontal   <= it.has_h;
        has_vertical     <= it.has_v;
        delta_horizontal <= it.d_h;
        delta_vertical   <= it.d_v;
        pos_horizontal   <= it.p_h;
        pos_vertical     <= it.p_v;
        do
            @(posedge clk);
        while (!in_ready);
        if (predict_gesture_events(it))
            effective_items++;
    endtask

    // Drop valid, wait for every predicted event, then hold off a little.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == tpgt_pkg::CFG_NATURAL_SCROLL)
            cfg_natural = data[0];
        else
            cfg_device = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers change only with the tracker idle.
    task automatic configure_tracker(input logic nat, input logic [DEV_W-1:0] dev);
        wait_drained();
        write_register(tpgt_pkg::CFG_NATURAL_SCROLL, CFG_DATA_W'(nat));
        write_register(tpgt_pkg::CFG_DEVICE_NUMBER, dev);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values; ignored samples, the full start/update/end
    // flow, axis flags that persist when unreported, and every remove case.
    task automatic test_gesture_flow();
        // All-zero sample with no gesture: dropped
        drive_item(sample_item(1'b1, 1'b1, '0, '0, POS_MAX, POS_MAX, rand_time()));
        // Deltas present but axes not reported: still counts as no motion
        drive_item(sample_item(1'b0, 1'b0, DELTA_MAX, DELTA_MIN, '0, '0, rand_time()));
        // Remove with nothing added: no event
        drive_item(remove_item(rand_time()));
        // First motion at extreme values: add, start, update
        drive_item(sample_item(1'b1, 1'b1, DELTA_MAX, DELTA_MIN, POS_MAX, POS_MAX,
                               TIME_MAX));
        // Horizontal only; vertical stays moving from before
        drive_item(sample_item(1'b1, 1'b0, -24'sd1, 24'sh000123, '0, '0, rand_time()));
        // Horizontal stops, vertical unreported: state change without an event
        drive_item(sample_item(1'b1, 1'b0, '0, 24'sd5, '0, '0, rand_time()));
        // Vertical stops too: end only
        drive_item(sample_item(1'b0, 1'b1, 24'sd9, '0, '0, '0, rand_time()));
        // New gesture on an added device: start and update, no add
        drive_item(sample_item(1'b0, 1'b1, '0, 24'sd1, '0, '0, '0));
        // Remove mid-gesture: end then remove
        drive_item(remove_item(rand_time()));
        drive_item(remove_item(rand_time()));
        drive_item(sample_item(1'b1, 1'b1, DELTA_MIN, '0, POS_W'($urandom),
                               POS_W'($urandom), rand_time()));
        drive_item(sample_item(1'b1, 1'b1, '0, '0, '0, '0, rand_time()));
        // Added device, no open gesture: remove only
        drive_item(remove_item(rand_time()));
    endtask

    // Inverted sign with the largest device number, then natural sign.
    task automatic test_register_extremes();
        configure_tracker(1'b0, 8'hFF);
        drive_item(sample_item(1'b1, 1'b1, 24'sd256, -24'sd256, POS_W'($urandom),
                               POS_W'($urandom), rand_time()));
        drive_item(sample_item(1'b1, 1'b1, DELTA_MAX, DELTA_MIN, '0, '0, rand_time()));
        drive_item(sample_item(1'b1, 1'b1, '0, '0, '0, '0, rand_time()));
        drive_item(remove_item(rand_time()));
        configure_tracker(1'b1, 8'hA5);
        drive_item(sample_item(1'b1, 1'b0, DELTA_MIN, '0, POS_MAX, '0, rand_time()));
        drive_item(remove_item(rand_time()));
    endtask

    // Drive both pan totals into their limits: with the sign inverted the
    // most negative delta climbs to the top and the most positive sinks.
    task automatic test_pan_saturation();
        configure_tracker(1'b0, 8'h5A);
        repeat (260)
            drive_item(sample_item(1'b1, 1'b1, DELTA_MIN, DELTA_MAX, POS_W'($urandom),
                                   POS_W'($urandom), rand_time()));
        drive_item(remove_item(rand_time()));
    endtask

    // One well-formed gesture with random content and a random ending.
    task automatic random_gesture();
        int           steps;
        finger_item_t it;
        steps    = $urandom_range(1, 8);
        it       = noise_item();
        it.op    = tpgt_pkg::OP_SAMPLE;
        // Guarantee the opening sample moves on at least one axis
        if ($urandom_range(0, 1))
        begin
            it.has_h = 1'b1;
            it.d_h   = nonzero_delta();
        end
        else
        begin
            it.has_v = 1'b1;
            it.d_v   = nonzero_delta();
        end
        drive_item(it);
        repeat (steps)
        begin
            it    = noise_item();
            it.op = tpgt_pkg::OP_SAMPLE;
            drive_item(it);
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                drive_item(sample_item(1'b1, 1'b1, '0, '0, POS_W'($urandom),
                                       POS_W'($urandom), rand_time()));
            6, 7:
                drive_item(remove_item(rand_time()));
            default:
                ;
        endcase
    endtask

    // Chunks of random gestures, each under fresh register values; one chunk
    // runs with no idling on either side.
    task automatic test_random_gestures();
        int chunk_goal;
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            configure_tracker(1'($urandom_range(0, 1)), DEV_W'($urandom));
            idle_on    = (chunk != 2);
            chunk_goal = effective_items + 12;
            while (effective_items < chunk_goal)
                case ($urandom_range(0, 9))
                    0:       drive_item(noise_item());
                    1:       drive_item(remove_item(rand_time()));
                    default: random_gesture();
                endcase
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Output side: backpressure and checking
    // ------------------------------------------------------------------

    // Stall the result channel in random bursts; hold ready high when
    // idling is off.
    initial
    begin : result_backpressure
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!idle_on)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = pick_gap();
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest pending event.
    always @(posedge clk)
    begin : result_check
        gesture_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: phase %0d time %h with nothing pending",
                             phase, out_time);
            end
            else
            begin
                want = pending_events.pop_front();
                if (phase !== want.ph || out_time !== want.stamp ||
                    out_pos_horizontal !== want.pos_h || out_pos_vertical !== want.pos_v ||
                    pan_horizontal !== want.pan_h || pan_vertical !== want.pan_v ||
                    device !== want.dev || last !== want.is_last)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch expected: ph %0d t %h pos %h/%h pan %0d/%0d dev %0d last %b",
                                 want.ph, want.stamp, want.pos_h, want.pos_v,
                                 want.pan_h, want.pan_v, want.dev, want.is_last);
                        $display("         actual:   ph %0d t %h pos %h/%h pan %0d/%0d dev %0d last %b",
                                 phase, out_time, out_pos_horizontal, out_pos_vertical,
                                 pan_horizontal, pan_vertical, device, last);
                    end
                end
            end
        end
    end

    // Abort when no channel completes a transaction for too long.
    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        operation        = tpgt_pkg::OP_SAMPLE;
        time_stamp       = '0;
        has_horizontal   = 1'b0;
        has_vertical     = 1'b0;
        delta_horizontal = '0;
        delta_vertical   = '0;
        pos_horizontal   = '0;
        pos_vertical     = '0;
        // Registers come out of reset as natural scroll on, device zero
        cfg_natural = 1'b1;
        cfg_device  = '0;
        clear_gesture_state();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_gesture_flow();
        test_register_extremes();
        test_pan_saturation();
        test_random_gestures();

        // Let every predicted event arrive, then give stray results time to show
        wait_drained();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
